// ===== sv/rlod_pkg.sv =====
`default_nettype none

package rlod_pkg;

    localparam int LEVEL_W = 16;
    localparam int FPB_W   = 9;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;

    localparam int MAX_PAIRS_DEF   = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam logic [IDX_W-1:0] REG_FRAMES_PER_BUFFER = 2'd0;
    localparam logic [IDX_W-1:0] REG_FULL_SCALE_LEVEL  = 2'd1;
    localparam logic [IDX_W-1:0] REG_ONSET_THRESHOLD   = 2'd2;
    localparam logic [IDX_W-1:0] REG_REARM_LEVEL       = 2'd3;

    localparam logic [FPB_W-1:0]   FRAMES_PER_BUFFER_RST = 9'd256;
    localparam logic [LEVEL_W-1:0] FULL_SCALE_LEVEL_RST  = 16'd6554;
    localparam logic [LEVEL_W-1:0] ONSET_THRESHOLD_RST   = 16'd58982;
    localparam logic [LEVEL_W-1:0] REARM_LEVEL_RST       = 16'd52429;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 16'hFFFF;

endpackage

`default_nettype wire

// ===== sv/rlod_div.sv =====
`default_nettype none

// restoring divider, one quotient bit per cycle
module rlod_div #(
    parameter int N = 40,
    parameter int D = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [N-1:0] dividend,
    input  wire logic [D-1:0] divisor,
    output logic              done,
    output logic [N-1:0]      quotient
);

    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  quo_reg, quo_next;
    logic [D-1:0]  rem_reg, rem_next;
    logic [D-1:0]  dvsr_reg, dvsr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [D:0]    rem_sh;
    logic [D:0]    rem_diff;

    assign rem_sh   = {rem_reg, quo_reg[N-1]};
    assign rem_diff = rem_sh - {1'b0, dvsr_reg};

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvsr_next = divisor;
            cnt_next  = CW'(N);
            run_next  = 1'b1;
        end else if (run_reg) begin
            if (rem_sh >= {1'b0, dvsr_reg}) begin
                rem_next = rem_diff[D-1:0];
                quo_next = {quo_reg[N-2:0], 1'b1};
            end else begin
                rem_next = rem_sh[D-1:0];
                quo_next = {quo_reg[N-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== sv/rlod_sqrt.sv =====
`default_nettype none

// integer square root, one root bit per cycle
module rlod_sqrt #(
    parameter int ARG_W = 40
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   start,
    input  wire logic [ARG_W-1:0]       arg,
    output logic                        done,
    output logic [(ARG_W+1)/2-1:0]      root
);

    localparam int RW = (ARG_W + 1) / 2;
    localparam int XW = 2 * RW;
    localparam int CW = $clog2(RW + 1);

    logic [XW-1:0]   x_reg, x_next;
    logic [RW+1:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [RW+3:0]   rem_sh;
    logic [RW+3:0]   trial;
    logic [RW+3:0]   rem_diff;

    assign rem_sh   = {rem_reg, x_reg[XW-1 -: 2]};
    assign trial    = {2'b00, root_reg, 2'b01};
    assign rem_diff = rem_sh - trial;

    always_comb begin
        x_next    = x_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            x_next    = XW'(arg);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(RW);
            run_next  = 1'b1;
        end else if (run_reg) begin
            x_next = {x_reg[XW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_diff[RW+1:0];
                root_next = {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[RW+1:0];
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        x_reg    <= x_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

// ===== sv/rms_level_onset_detector.sv =====
// RMS level meter with onset detection.
// Input channel (s_valid/s_ready): one stereo pair per transaction, signed samples.
// Result channel (m_valid/m_ready): one result per buffer of frames_per_buffer
// pairs (0 read as 1, max MAX_PAIRS): RMS, smoothed and scaled level, onset flag.
// Configuration: cfg_wr_en/cfg_wr_index/cfg_wr_data, one register per cycle.
// Each pair is squared by a shift-add multiplier, one multiplier bit per cycle:
// s_ready stays low from acceptance of a pair until both samples are squared
// and summed, so no new pair is taken before the last one is through.
// The last pair of a buffer then runs the serial divider for the mean square,
// the serial square root and, unless the full-scale level is zero, the divider
// again for scaling.
// The result sits in an output register; new pairs are taken while it waits.
// If the receiver stalls, the block holds at the next buffer end until
// the previous result is taken.
// Reset restores register defaults and clears the sum, pair count, smoothed
// level and previous scaled level; no result is pending after reset.
`default_nettype none

module rms_level_onset_detector #(
    parameter int MAX_PAIRS   = rlod_pkg::MAX_PAIRS_DEF,
    parameter int SAMPLE_BITS = rlod_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]    s_left_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]    s_right_sample,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [rlod_pkg::LEVEL_W-1:0]          m_rms_level,
    output logic [rlod_pkg::LEVEL_W-1:0]          m_smoothed_level,
    output logic [rlod_pkg::LEVEL_W-1:0]          m_scaled_level,
    output logic                                  m_onset,
    input  wire logic                             cfg_wr_en,
    input  wire logic [rlod_pkg::IDX_W-1:0]       cfg_wr_index,
    input  wire logic [rlod_pkg::CFG_W-1:0]       cfg_wr_data
);

    localparam int LW     = rlod_pkg::LEVEL_W;
    localparam int FW     = rlod_pkg::FPB_W;
    localparam int SB     = SAMPLE_BITS;
    localparam int L      = $clog2(MAX_PAIRS);
    localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
    localparam int SQ_W   = 2 * SB;
    localparam int SUM_W  = 2 * SB - 2 + L;
    localparam int UP     = (SB <= 17) ? 34 - 2 * SB : 0;
    localparam int DOWN   = (SB > 17) ? 2 * SB - 34 : 0;
    localparam int QW     = SUM_W + UP;
    localparam int ARG_W  = QW - DOWN;
    localparam int RW     = (ARG_W + 1) / 2;
    localparam int DV_W   = (CNT_W + 1 > LW) ? CNT_W + 1 : LW;
    localparam int CMP_W  = (CNT_W > FW) ? CNT_W : FW;
    localparam int BIT_W  = $clog2(SB + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SQR   = 3'd1;
    localparam logic [2:0] ST_ACC   = 3'd2;
    localparam logic [2:0] ST_MEAN  = 3'd3;
    localparam logic [2:0] ST_ROOT  = 3'd4;
    localparam logic [2:0] ST_SCALE = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    // configuration
    logic [FW-1:0] fpb_reg, fpb_next;
    logic [LW-1:0] full_reg, full_next;
    logic [LW-1:0] thr_reg, thr_next;
    logic [LW-1:0] rearm_reg, rearm_next;

    // control and datapath
    logic [2:0]       state_reg, state_next;
    logic [SB-1:0]    mcand_reg, mcand_next;
    logic [SB-1:0]    mplr_reg, mplr_next;
    logic [SB-1:0]    mag_r_reg, mag_r_next;
    logic [SQ_W-1:0]  prod_reg, prod_next;
    logic [BIT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic             second_reg, second_next;
    logic [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0] pc_reg, pc_next;
    logic [LW-1:0]    smooth_reg, smooth_next;
    logic [LW-1:0]    prev_reg, prev_next;
    logic [LW-1:0]    rms_reg, rms_next;
    logic [LW-1:0]    scaled_reg, scaled_next;
    logic             div_go_reg, div_go_next;
    logic             sqrt_go_reg, sqrt_go_next;

    // result register
    logic             m_valid_reg, m_valid_next;
    logic [LW-1:0]    m_rms_reg, m_rms_next;
    logic [LW-1:0]    m_smooth_reg, m_smooth_next;
    logic [LW-1:0]    m_scaled_reg, m_scaled_next;
    logic             m_onset_reg, m_onset_next;

    logic [SB-1:0]    raw_l, raw_r, mag_l, mag_r;
    logic [CMP_W-1:0] fpb_ext, max_ext, limit;
    logic [CNT_W-1:0] pc_inc;
    logic             buf_end;
    logic [QW-1:0]    div_dividend, div_quo;
    logic [DV_W-1:0]  div_divisor;
    logic             div_done;
    logic [ARG_W-1:0] sqrt_arg;
    logic [RW-1:0]    sqrt_root;
    logic [RW:0]      root_x;
    logic             sqrt_done;
    logic [LW-1:0]    rms_clamped;
    logic [LW:0]      smooth_sum;
    logic [2*LW-1:0]  scale_num;

    assign raw_l = s_left_sample;
    assign raw_r = s_right_sample;
    assign mag_l = raw_l[SB-1] ? (~raw_l + 1'b1) : raw_l;
    assign mag_r = raw_r[SB-1] ? (~raw_r + 1'b1) : raw_r;

    assign fpb_ext = CMP_W'(fpb_reg);
    assign max_ext = CMP_W'(MAX_PAIRS);
    assign limit   = (fpb_reg == '0) ? CMP_W'(1) :
                     ((fpb_ext > max_ext) ? max_ext : fpb_ext);
    assign pc_inc  = pc_reg + 1'b1;
    assign buf_end = (CMP_W'(pc_inc) >= limit);

    assign scale_num    = {smooth_reg, {LW{1'b0}}} - {{LW{1'b0}}, smooth_reg};
    assign div_dividend = (state_reg == ST_SCALE) ? QW'(scale_num)
                                                  : (QW'(sum_reg) << UP);
    assign div_divisor  = (state_reg == ST_SCALE) ? DV_W'(full_reg)
                                                  : DV_W'({pc_reg, 1'b0});

    assign sqrt_arg    = ARG_W'(div_quo >> DOWN);
    assign root_x      = (RW + 1)'(sqrt_root);
    assign rms_clamped = (root_x > (RW + 1)'(rlod_pkg::LEVEL_MAX)) ? rlod_pkg::LEVEL_MAX
                                                                   : root_x[LW-1:0];
    assign smooth_sum  = {1'b0, smooth_reg} + {1'b0, rms_clamped};

    rlod_div #(
        .N(QW),
        .D(DV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_go_reg),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    rlod_sqrt #(
        .ARG_W(ARG_W)
    ) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_go_reg),
        .arg     (sqrt_arg),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    always_comb begin
        fpb_next   = fpb_reg;
        full_next  = full_reg;
        thr_next   = thr_reg;
        rearm_next = rearm_reg;
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                rlod_pkg::REG_FRAMES_PER_BUFFER: fpb_next   = cfg_wr_data[FW-1:0];
                rlod_pkg::REG_FULL_SCALE_LEVEL:  full_next  = cfg_wr_data[LW-1:0];
                rlod_pkg::REG_ONSET_THRESHOLD:   thr_next   = cfg_wr_data[LW-1:0];
                rlod_pkg::REG_REARM_LEVEL:       rearm_next = cfg_wr_data[LW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next    = state_reg;
        mcand_next    = mcand_reg;
        mplr_next     = mplr_reg;
        mag_r_next    = mag_r_reg;
        prod_next     = prod_reg;
        bit_cnt_next  = bit_cnt_reg;
        second_next   = second_reg;
        sum_next      = sum_reg;
        pc_next       = pc_reg;
        smooth_next   = smooth_reg;
        prev_next     = prev_reg;
        rms_next      = rms_reg;
        scaled_next   = scaled_reg;
        div_go_next   = 1'b0;
        sqrt_go_next  = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_rms_next    = m_rms_reg;
        m_smooth_next = m_smooth_reg;
        m_scaled_next = m_scaled_reg;
        m_onset_next  = m_onset_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mcand_next   = mag_l;
                    mplr_next    = mag_l;
                    mag_r_next   = mag_r;
                    prod_next    = '0;
                    bit_cnt_next = BIT_W'(SB);
                    second_next  = 1'b0;
                    state_next   = ST_SQR;
                end
            end
            ST_SQR: begin
                prod_next    = {prod_reg[SQ_W-2:0], 1'b0}
                             + (mplr_reg[SB-1] ? SQ_W'(mcand_reg) : '0);
                mplr_next    = {mplr_reg[SB-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BIT_W'(1)) begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                sum_next = sum_reg + SUM_W'(prod_reg[SQ_W-1:2]);
                if (!second_reg) begin
                    mcand_next   = mag_r_reg;
                    mplr_next    = mag_r_reg;
                    prod_next    = '0;
                    bit_cnt_next = BIT_W'(SB);
                    second_next  = 1'b1;
                    state_next   = ST_SQR;
                end else begin
                    pc_next = pc_inc;
                    if (buf_end) begin
                        div_go_next = 1'b1;
                        state_next  = ST_MEAN;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MEAN: begin
                if (div_done) begin
                    sqrt_go_next = 1'b1;
                    state_next   = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (sqrt_done) begin
                    rms_next    = rms_clamped;
                    smooth_next = smooth_sum[LW:1];
                    if (full_reg == '0) begin
                        scaled_next = '0;
                        state_next  = ST_OUT;
                    end else begin
                        div_go_next = 1'b1;
                        state_next  = ST_SCALE;
                    end
                end
            end
            ST_SCALE: begin
                if (div_done) begin
                    scaled_next = (div_quo[QW-1:LW] != '0) ? rlod_pkg::LEVEL_MAX
                                                          : div_quo[LW-1:0];
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_rms_next    = rms_reg;
                    m_smooth_next = smooth_reg;
                    m_scaled_next = scaled_reg;
                    m_onset_next  = (scaled_reg > thr_reg) && (prev_reg < rearm_reg);
                    prev_next     = scaled_reg;
                    sum_next      = '0;
                    pc_next       = '0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fpb_reg     <= rlod_pkg::FRAMES_PER_BUFFER_RST;
            full_reg    <= rlod_pkg::FULL_SCALE_LEVEL_RST;
            thr_reg     <= rlod_pkg::ONSET_THRESHOLD_RST;
            rearm_reg   <= rlod_pkg::REARM_LEVEL_RST;
            state_reg   <= ST_IDLE;
            sum_reg     <= '0;
            pc_reg      <= '0;
            smooth_reg  <= '0;
            prev_reg    <= '0;
            div_go_reg  <= 1'b0;
            sqrt_go_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            fpb_reg     <= fpb_next;
            full_reg    <= full_next;
            thr_reg     <= thr_next;
            rearm_reg   <= rearm_next;
            state_reg   <= state_next;
            sum_reg     <= sum_next;
            pc_reg      <= pc_next;
            smooth_reg  <= smooth_next;
            prev_reg    <= prev_next;
            div_go_reg  <= div_go_next;
            sqrt_go_reg <= sqrt_go_next;
            m_valid_reg <= m_valid_next;
        end
        mcand_reg    <= mcand_next;
        mplr_reg     <= mplr_next;
        mag_r_reg    <= mag_r_next;
        prod_reg     <= prod_next;
        bit_cnt_reg  <= bit_cnt_next;
        second_reg   <= second_next;
        rms_reg      <= rms_next;
        scaled_reg   <= scaled_next;
        m_rms_reg    <= m_rms_next;
        m_smooth_reg <= m_smooth_next;
        m_scaled_reg <= m_scaled_next;
        m_onset_reg  <= m_onset_next;
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_rms_level      = m_rms_reg;
    assign m_smoothed_level = m_smooth_reg;
    assign m_scaled_level   = m_scaled_reg;
    assign m_onset          = m_onset_reg;

endmodule

`default_nettype wire
